@@ rtl/ita_pkg.sv @@
// Shared types and constants of the track association block.
package ita_pkg;

  localparam int COORD_W   = 18;
  localparam int SIZE_W    = 17;
  localparam int TRACK_W   = 6;
  localparam int VIDX_W    = 5;
  localparam int IOU_W     = 16;
  localparam int AGE_W     = 16;
  localparam int AREA_W    = 2 * SIZE_W;
  localparam int QUO_W     = IOU_W + 1;
  localparam int VBOX_W    = 2 * COORD_W + 2 * SIZE_W;
  localparam int TREC_W    = IOU_W + AGE_W + TRACK_W + 1;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 48;
  localparam int PADDR_W   = 3;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_MATCH = 2'd2;

  localparam logic [PADDR_W-1:0] REG_IOU_THRESHOLD = '0;

  typedef struct packed {
    logic latch;
    logic exec_clr;
    logic exec_load;
    logic area_a;
    logic scan_init;
    logic vis_rd;
    logic geom;
    logic mul_inter;
    logic mul_b;
    logic uni;
    logic div_step;
    logic cmp;
    logic scan_inc;
    logic prev_wr;
    logic trk_rd;
    logic upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       trk_ok;
    logic       scan_end;
    logic       ovl;
    logic       div_last;
    logic       found;
    logic       pick_owned;
  } sts_t;

endpackage

@@ rtl/ita_ram.sv @@
// Generic single-port RAM with registered read.
module ita_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic                        re_i,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] addr_i,
  input  logic [W-1:0]                wdata_i,
  output logic [W-1:0]                rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/ita_ctrl.sv @@
// Sequencer of the track association block.
module ita_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ita_pkg::sts_t sts_i,
  output ita_pkg::cmd_t cmd_o
);
  import ita_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_AREA = 4'd3;
  localparam logic [3:0] S_NEXT = 4'd4;
  localparam logic [3:0] S_GEOM = 4'd5;
  localparam logic [3:0] S_MULI = 4'd6;
  localparam logic [3:0] S_MULB = 4'd7;
  localparam logic [3:0] S_UNI  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_CMP  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_RDT  = 4'd12;
  localparam logic [3:0] S_UPD  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0] state_q, state_d;
  logic       ovld_q, ovld_d;
  logic       out_free;

  assign out_free    = !ovld_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ovld_d  = ovld_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.act == ACT_CLEAR || sts_i.act == ACT_LOAD) begin
          state_d = S_EXEC;
        end else if (sts_i.act == ACT_MATCH && sts_i.trk_ok) begin
          state_d = S_AREA;
        end else begin
          state_d = S_DONE;
        end
      end
      S_EXEC: begin
        cmd_o.exec_clr  = (sts_i.act == ACT_CLEAR);
        cmd_o.exec_load = (sts_i.act == ACT_LOAD);
        state_d         = S_DONE;
      end
      S_AREA: begin
        cmd_o.area_a    = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d         = S_NEXT;
      end
      S_NEXT: begin
        if (sts_i.scan_end) begin
          state_d = S_FIN;
        end else begin
          cmd_o.vis_rd = 1'b1;
          state_d      = S_GEOM;
        end
      end
      S_GEOM: begin
        cmd_o.geom = 1'b1;
        state_d    = S_MULI;
      end
      S_MULI: begin
        if (sts_i.ovl) begin
          cmd_o.mul_inter = 1'b1;
          state_d         = S_MULB;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_NEXT;
        end
      end
      S_MULB: begin
        cmd_o.mul_b = 1'b1;
        state_d     = S_UNI;
      end
      S_UNI: begin
        cmd_o.uni = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp      = 1'b1;
        cmd_o.scan_inc = 1'b1;
        state_d        = S_NEXT;
      end
      S_FIN: begin
        if (!sts_i.found) begin
          state_d = S_DONE;
        end else begin
          cmd_o.prev_wr = sts_i.pick_owned;
          state_d       = S_RDT;
        end
      end
      S_RDT: begin
        cmd_o.trk_rd = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ovld_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end
endmodule

@@ rtl/ita_datapath.sv @@
// Datapath of the track association block: tables, IoU arithmetic and result register.
module ita_datapath #(
  parameter int TRACK_SLOTS  = 64,
  parameter int VISION_SLOTS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ita_pkg::cmd_t                   cmd_i,
  output ita_pkg::sts_t                   sts_o,
  input  logic [1:0]                      in_act_i,
  input  logic [ita_pkg::IN_DATA_W-1:0]   in_data_i,
  input  logic [ita_pkg::IOU_W-1:0]       thr_i,
  output logic [ita_pkg::OUT_DATA_W-1:0]  out_data_o
);
  import ita_pkg::*;

  localparam int VAW = (VISION_SLOTS > 1) ? $clog2(VISION_SLOTS) : 1;
  localparam int CW  = $clog2(VISION_SLOTS + 1);
  localparam int TAW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;

  logic [1:0]                act_q;
  logic [TRACK_W-1:0]        trk_q;
  logic signed [COORD_W-1:0] ax_q, ay_q;
  logic [SIZE_W-1:0]         aw_q, ah_q;

  logic [CW-1:0]      cnt_q, i_q;
  logic               owned_q [VISION_SLOTS];
  logic [TRACK_W-1:0] owner_q [VISION_SLOTS];
  logic               tv_q    [TRACK_SLOTS];

  logic [VAW-1:0] iidx, slot;
  logic           room;
  assign iidx = i_q[VAW-1:0];
  assign slot = cnt_q[VAW-1:0];
  assign room = (32'(cnt_q) < VISION_SLOTS);

  logic [VBOX_W-1:0] vrd;
  logic [VAW-1:0]    vaddr;
  assign vaddr = cmd_i.exec_load ? slot : iidx;

  ita_ram #(.W(VBOX_W), .D(VISION_SLOTS)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec_load && room),
    .re_i    (cmd_i.vis_rd),
    .addr_i  (vaddr),
    .wdata_i ({ah_q, aw_q, ay_q, ax_q}),
    .rdata_o (vrd)
  );

  logic signed [COORD_W-1:0] bx, by;
  logic [SIZE_W-1:0]         bw, bh;
  assign bx = vrd[COORD_W-1:0];
  assign by = vrd[2*COORD_W-1:COORD_W];
  assign bw = vrd[2*COORD_W+SIZE_W-1:2*COORD_W];
  assign bh = vrd[VBOX_W-1:2*COORD_W+SIZE_W];

  logic [VAW-1:0]  pick_q;
  logic [TAW-1:0]  taddr;
  logic [TREC_W-1:0] trd, twdata;
  logic [IOU_W-1:0]  best_q, pick_ratio_q;
  logic [AGE_W-1:0]  age_old, age_new;

  always_comb begin
    if (cmd_i.vis_rd) begin
      taddr = TAW'(owner_q[iidx]);
    end else if (cmd_i.prev_wr) begin
      taddr = TAW'(owner_q[pick_q]);
    end else begin
      taddr = TAW'(trk_q);
    end
  end

  assign age_old = tv_q[TAW'(trk_q)] ? trd[IOU_W+AGE_W-1:IOU_W] : '0;
  assign age_new = (age_old == '1) ? age_old : age_old + 1'b1;
  assign twdata  = cmd_i.prev_wr ? {1'b0, {TRACK_W{1'b0}}, {AGE_W{1'b0}}, pick_ratio_q}
                                 : {1'b1, TRACK_W'(pick_q), age_new, best_q};

  ita_ram #(.W(TREC_W), .D(TRACK_SLOTS)) u_trk_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.prev_wr || cmd_i.upd),
    .re_i    (cmd_i.vis_rd || cmd_i.trk_rd),
    .addr_i  (taddr),
    .wdata_i (twdata),
    .rdata_o (trd)
  );

  // Overlap of the track box with the stored box.
  logic signed [COORD_W+1:0] a_l, a_r, b_l, b_r, o_l, o_r;
  logic signed [COORD_W+1:0] a_t, a_b, b_t, b_b, o_t, o_b;
  logic signed [COORD_W+2:0] iw, ih;
  assign a_l = (COORD_W+2)'(ax_q);
  assign a_r = (COORD_W+2)'(ax_q) + $signed({3'b000, aw_q});
  assign b_l = (COORD_W+2)'(bx);
  assign b_r = (COORD_W+2)'(bx) + $signed({3'b000, bw});
  assign a_t = (COORD_W+2)'(ay_q);
  assign a_b = (COORD_W+2)'(ay_q) + $signed({3'b000, ah_q});
  assign b_t = (COORD_W+2)'(by);
  assign b_b = (COORD_W+2)'(by) + $signed({3'b000, bh});
  assign o_l = (a_l > b_l) ? a_l : b_l;
  assign o_r = (a_r < b_r) ? a_r : b_r;
  assign o_t = (a_t > b_t) ? a_t : b_t;
  assign o_b = (a_b < b_b) ? a_b : b_b;
  assign iw  = (COORD_W+3)'(o_r) - (COORD_W+3)'(o_l);
  assign ih  = (COORD_W+3)'(o_b) - (COORD_W+3)'(o_t);

  logic [SIZE_W-1:0] iw_q, ih_q, ma, mb;
  logic              ovl_q, own_q, own_tv_q;
  logic [IOU_W-1:0]  own_ratio_q;
  logic [AREA_W-1:0] prod, area_a_q, area_b_q, inter_q;
  logic [AREA_W:0]   uni_q;
  logic [AREA_W+1:0] rem_q, rem_t;
  logic [QUO_W-1:0]  quo_q;
  logic [4:0]        dcnt_q;
  logic              ge, found_q;
  logic [IOU_W-1:0]  v;

  always_comb begin
    if (cmd_i.area_a) begin
      ma = aw_q;
      mb = ah_q;
    end else if (cmd_i.mul_b) begin
      ma = bw;
      mb = bh;
    end else begin
      ma = iw_q;
      mb = ih_q;
    end
  end
  assign prod = ma * mb;

  assign rem_t = (dcnt_q == '0) ? rem_q : {rem_q[AREA_W:0], 1'b0};
  assign ge    = (rem_t >= {1'b0, uni_q});
  assign v     = quo_q[QUO_W-1] ? '1 : quo_q[IOU_W-1:0];

  // Result fields before they reach the output register.
  logic               r_match, r_disp, r_full;
  logic [VIDX_W-1:0]  r_vidx;
  logic [IOU_W-1:0]   r_iou;
  logic [TRACK_W-1:0] r_dtrk;
  logic [AGE_W-1:0]   r_age;
  logic [OUT_DATA_W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q   <= in_act_i;
      trk_q   <= in_data_i[5:0];
      ax_q    <= in_data_i[23:6];
      ay_q    <= in_data_i[41:24];
      aw_q    <= in_data_i[58:42];
      ah_q    <= in_data_i[75:59];
      r_match <= 1'b0;
      r_vidx  <= '0;
      r_iou   <= '0;
      r_disp  <= 1'b0;
      r_dtrk  <= '0;
      r_age   <= '0;
      r_full  <= 1'b0;
    end
    if (cmd_i.exec_load) begin
      if (room) begin
        owner_q[slot] <= '0;
        r_vidx        <= VIDX_W'(slot);
      end else begin
        r_full <= 1'b1;
      end
    end
    if (cmd_i.area_a) begin
      area_a_q <= prod;
    end
    if (cmd_i.scan_init) begin
      i_q     <= '0;
      best_q  <= '0;
      found_q <= 1'b0;
    end
    if (cmd_i.vis_rd) begin
      own_q    <= owned_q[iidx];
      own_tv_q <= tv_q[TAW'(owner_q[iidx])];
    end
    if (cmd_i.geom) begin
      iw_q        <= iw[SIZE_W-1:0];
      ih_q        <= ih[SIZE_W-1:0];
      ovl_q       <= (iw > 0) && (ih > 0);
      own_ratio_q <= own_tv_q ? trd[IOU_W-1:0] : '0;
    end
    if (cmd_i.mul_inter) begin
      inter_q <= prod;
    end
    if (cmd_i.mul_b) begin
      area_b_q <= prod;
    end
    if (cmd_i.uni) begin
      uni_q  <= {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter_q};
      rem_q  <= {2'b00, inter_q};
      dcnt_q <= '0;
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? rem_t - {1'b0, uni_q} : rem_t;
      quo_q  <= {quo_q[QUO_W-2:0], ge};
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.cmp) begin
      if (v > best_q && v > thr_i && (!own_q || v > own_ratio_q)) begin
        best_q       <= v;
        pick_q       <= iidx;
        found_q      <= 1'b1;
        pick_ratio_q <= own_ratio_q;
      end
    end
    if (cmd_i.scan_inc) begin
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.prev_wr) begin
      r_disp <= 1'b1;
      r_dtrk <= owner_q[pick_q];
    end
    if (cmd_i.upd) begin
      owner_q[pick_q] <= trk_q;
      r_match         <= 1'b1;
      r_vidx          <= VIDX_W'(pick_q);
      r_iou           <= best_q;
      r_age           <= age_new;
    end
    if (cmd_i.out_load) begin
      out_q <= {2'b00, r_full, r_age, r_dtrk, r_disp, r_iou, r_vidx, r_match};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int k = 0; k < VISION_SLOTS; k++) begin
        owned_q[k] <= 1'b0;
      end
      for (int k = 0; k < TRACK_SLOTS; k++) begin
        tv_q[k] <= 1'b0;
      end
    end else begin
      if (cmd_i.exec_clr) begin
        cnt_q <= '0;
        for (int k = 0; k < VISION_SLOTS; k++) begin
          owned_q[k] <= 1'b0;
        end
      end
      if (cmd_i.exec_load && room) begin
        owned_q[slot] <= 1'b0;
        cnt_q         <= cnt_q + 1'b1;
      end
      if (cmd_i.prev_wr || cmd_i.upd) begin
        tv_q[taddr] <= 1'b1;
      end
      if (cmd_i.upd) begin
        owned_q[pick_q] <= 1'b1;
      end
    end
  end

  assign sts_o.act        = act_q;
  assign sts_o.trk_ok     = (32'(trk_q) < TRACK_SLOTS);
  assign sts_o.scan_end   = (i_q >= cnt_q);
  assign sts_o.ovl        = ovl_q;
  assign sts_o.div_last   = (dcnt_q == 5'(QUO_W - 1));
  assign sts_o.found      = found_q;
  assign sts_o.pick_owned = owned_q[pick_q];
  assign out_data_o       = out_q;
endmodule

@@ rtl/iou_track_association.sv @@
// Top level of the greedy IoU track association block.
// Each transaction on the input stream is one action chosen by tuser: clear the frame, load a
// camera box into the next free table slot, or match a radar track box against every loaded
// box. Per box a match makes the registered table read, the overlap geometry, two products on
// the shared 17 by 17 multiplier and a 17-step restoring division; boxes with no overlap skip
// the products and the division. The result is held in an output register, so the next
// transaction is accepted while it waits. The threshold register is written over APB.
module iou_track_association #(
  parameter int TRACK_SLOTS  = 64,
  parameter int VISION_SLOTS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // track_index, box_x, box_y, box_w, box_h, zero fill
  input  logic [ita_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // action
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // matched, vision_index, iou_value, displaced, displaced_track, fusion_age, table_full, zero fill
  output logic [ita_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ita_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ita_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [IOU_W-1:0] thr_q;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_IOU_THRESHOLD) ? {16'h0000, thr_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'h8000;
    end else if (psel && penable && pwrite && pready && paddr == REG_IOU_THRESHOLD) begin
      thr_q <= pwdata[IOU_W-1:0];
    end
  end

  ita_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ita_datapath #(
    .TRACK_SLOTS  (TRACK_SLOTS),
    .VISION_SLOTS (VISION_SLOTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_act_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .thr_i      (thr_q),
    .out_data_o (m_axis_tdata)
  );

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[21:6] == '0 && !m_axis_tdata[22])
    else $error("unmatched result carries an IoU or a displaced track");

  a_full_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[45]))
    else $error("result both matched and rejected");

  a_above_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[21:6] > thr_q)
    else $error("association at or below the threshold");
endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the greedy IoU track association block.
module tb;
  import ita_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int NTRK = 64;
  localparam int NVIS = 32;
  localparam int SETTLE = 800;

  typedef struct packed {
    logic        matched;
    logic [4:0]  vidx;
    logic [15:0] iou;
    logic        disp;
    logic [5:0]  dtrk;
    logic [15:0] age;
    logic        full;
  } assoc_t;

  typedef struct {
    logic [1:0]         act;
    logic [5:0]         trk;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic [16:0]        w;
    logic [16:0]        h;
    bit                 typed;
    assoc_t             res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  iou_track_association u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the block state.
  logic [15:0] thr;
  longint      vx[NVIS], vy[NVIS], vw[NVIS], vh[NVIS];
  bit          vowned[NVIS];
  int          vowner[NVIS];
  int          vcount;
  int          tratio[NTRK], tage[NTRK];

  assoc_t pending[$];
  int     mismatches = 0;
  int     failures = 0;
  int     items = 0;
  int     gap_pct = 0;
  int     stall_pct = 0;

  function automatic int box_overlap(longint ax, longint ay, longint aw, longint ah,
                                     longint bx, longint by, longint bw, longint bh);
    longint l, t, r, b, iw, ih, inter, uni, q;
    l = (ax > bx) ? ax : bx;
    t = (ay > by) ? ay : by;
    r = (ax + aw < bx + bw) ? ax + aw : bx + bw;
    b = (ay + ah < by + bh) ? ay + ah : by + bh;
    iw = r - l;
    ih = b - t;
    if (iw <= 0 || ih <= 0) return 0;
    inter = iw * ih;
    uni = aw * ah + bw * bh - inter;
    if (uni <= 0) return 0;
    q = (inter << 16) / uni;
    return (q > 65535) ? 65535 : int'(q);
  endfunction

  function automatic assoc_t associate(logic [1:0] act, logic [5:0] trk, logic signed [17:0] x,
                                       logic signed [17:0] y, logic [16:0] w, logic [16:0] h);
    assoc_t r;
    int best, pick, v, prev;
    bit found;
    r = '0;
    best = 0;
    pick = 0;
    found = 0;
    case (act)
      ACT_CLEAR: begin
        vcount = 0;
        foreach (vowned[j]) vowned[j] = 0;
      end
      ACT_LOAD: begin
        if (vcount < NVIS) begin
          vx[vcount] = x;
          vy[vcount] = y;
          vw[vcount] = w;
          vh[vcount] = h;
          vowned[vcount] = 0;
          vowner[vcount] = 0;
          r.vidx = vcount[4:0];
          vcount++;
        end else begin
          r.full = 1'b1;
        end
      end
      ACT_MATCH: begin
        for (int i = 0; i < vcount; i++) begin
          v = box_overlap(x, y, w, h, vx[i], vy[i], vw[i], vh[i]);
          if (v > best && v > thr && (!vowned[i] || v > tratio[vowner[i]])) begin
            best = v;
            pick = i;
            found = 1;
          end
        end
        if (found) begin
          if (vowned[pick]) begin
            prev = vowner[pick];
            tage[prev] = 0;
            r.disp = 1'b1;
            r.dtrk = prev[5:0];
          end
          tratio[trk] = best;
          if (tage[trk] < 65535) tage[trk]++;
          vowned[pick] = 1;
          vowner[pick] = trk;
          r.matched = 1'b1;
          r.vidx = pick[4:0];
          r.iou = best[15:0];
          r.age = tage[trk][15:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [1:0] act, logic [5:0] trk, logic signed [17:0] x,
                           logic signed [17:0] y, logic [16:0] w, logic [16:0] h,
                           bit typed = 0, assoc_t res = '0);
    assoc_t e;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {4'b0, h, w, y, x, trk};
    do @(posedge clk_i); while (!s_axis_tready);
    e = associate(act, trk, x, y, w, h);
    pending.push_back(typed ? res : e);
    items++;
  endtask

  task automatic write_threshold(logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_IOU_THRESHOLD;
    pwdata <= {16'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thr = value;
  endtask

  // A frame is a clear, a few loads and matches near the loaded boxes; some are pure noise.
  task automatic run_frame();
    int n, m, s;
    longint px, py, pw, ph;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 4))
        send_item(2'($urandom_range(3)), 6'($urandom), 18'($urandom), 18'($urandom),
                  17'($urandom), 17'($urandom));
      return;
    end
    send_item(ACT_CLEAR, 6'($urandom), 18'($urandom), 18'($urandom), 17'($urandom),
              17'($urandom));
    n = ($urandom_range(19) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 6);
    repeat (n)
      send_item(ACT_LOAD, 6'($urandom), 18'(int'($urandom_range(4000)) - 2000),
                18'(int'($urandom_range(4000)) - 2000), 17'($urandom_range(16, 800)),
                17'($urandom_range(16, 800)));
    m = $urandom_range(1, 8);
    repeat (m) begin
      s = $urandom_range(vcount - 1);
      px = vx[s] + $urandom_range(40) - 20;
      py = vy[s] + $urandom_range(40) - 20;
      pw = vw[s] + $urandom_range(40) - 20;
      ph = vh[s] + $urandom_range(40) - 20;
      if ($urandom_range(3) == 0) begin
        px = vx[s];
        py = vy[s];
        pw = vw[s];
        ph = vh[s];
      end
      if (pw < 0) pw = 0;
      if (ph < 0) ph = 0;
      send_item(ACT_MATCH,
                ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7)),
                18'(px), 18'(py), 17'(pw), 17'(ph));
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    assoc_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[0], m_axis_tdata[5:1], m_axis_tdata[21:6], m_axis_tdata[22],
              m_axis_tdata[28:23], m_axis_tdata[44:29], m_axis_tdata[45]};
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result transaction %h", m_axis_tdata);
      end else begin
        want = pending.pop_front();
        if (got.matched !== want.matched || got.vidx !== want.vidx || got.iou !== want.iou ||
            got.disp !== want.disp || got.dtrk !== want.dtrk || got.age !== want.age ||
            got.full !== want.full) begin
          mismatches++;
          failures++;
          if (mismatches <= 10)
            $display("mismatch: expected m=%0d v=%0d iou=%0d d=%0d dt=%0d age=%0d full=%0d, got m=%0d v=%0d iou=%0d d=%0d dt=%0d age=%0d full=%0d",
                     want.matched, want.vidx, want.iou, want.disp, want.dtrk, want.age,
                     want.full, got.matched, got.vidx, got.iou, got.disp, got.dtrk, got.age,
                     got.full);
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("iou_track_association regression: fail");
    $finish;
  end

  initial begin
    row_t dir[$];
    logic [15:0] thr_plan[5];
    int gap_plan[5], stall_plan[5];
    thr = 16'd32768;
    vcount = 0;
    foreach (vowned[j]) begin
      vowned[j] = 0;
      vowner[j] = 0;
    end
    foreach (tratio[j]) begin
      tratio[j] = 0;
      tage[j] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir.push_back('{ACT_CLEAR, 6'd0, 18'sd0, 18'sd0, 17'd0, 17'd0, 1, '0});
    dir.push_back('{ACT_MATCH, 6'd5, 18'sd0, 18'sd0, 17'd160, 17'd160, 1, '0});
    dir.push_back('{ACT_LOAD, 6'd63, -18'sd131072, -18'sd131072, 17'd131071, 17'd131071,
                    1, '{1'b0, 5'd0, 16'd0, 1'b0, 6'd0, 16'd0, 1'b0}});
    dir.push_back('{ACT_LOAD, 6'd0, 18'sd131071, 18'sd131071, 17'd0, 17'd0,
                    1, '{1'b0, 5'd1, 16'd0, 1'b0, 6'd0, 16'd0, 1'b0}});
    dir.push_back('{ACT_LOAD, 6'd0, 18'sd0, 18'sd0, 17'd160, 17'd160,
                    1, '{1'b0, 5'd2, 16'd0, 1'b0, 6'd0, 16'd0, 1'b0}});
    dir.push_back('{ACT_LOAD, 6'd0, 18'sd0, 18'sd0, 17'd160, 17'd160, 0, '0});
    dir.push_back('{ACT_MATCH, 6'd0, 18'sd0, 18'sd0, 17'd160, 17'd160,
                    1, '{1'b1, 5'd2, 16'd65535, 1'b0, 6'd0, 16'd1, 1'b0}});
    dir.push_back('{ACT_MATCH, 6'd1, 18'sd0, 18'sd0, 17'd160, 17'd160, 0, '0});
    dir.push_back('{ACT_MATCH, 6'd2, 18'sd0, 18'sd0, 17'd160, 17'd200, 0, '0});
    dir.push_back('{ACT_MATCH, 6'd2, 18'sd0, 18'sd0, 17'd160, 17'd160, 0, '0});
    dir.push_back('{ACT_MATCH, 6'd3, 18'sd10, 18'sd0, 17'd160, 17'd160, 0, '0});
    dir.push_back('{ACT_MATCH, 6'd63, 18'sd0, 18'sd0, 17'd160, 17'd160, 0, '0});
    dir.push_back('{ACT_MATCH, 6'd4, -18'sd131072, -18'sd131072, 17'd131071, 17'd131071,
                    0, '0});
    dir.push_back('{ACT_MATCH, 6'd4, 18'sd131071, 18'sd131071, 17'd131071, 17'd131071,
                    1, '0});
    dir.push_back('{ACT_SPARE, 6'd63, -18'sd1, -18'sd1, 17'd131071, 17'd131071, 1, '0});
    dir.push_back('{ACT_LOAD, 6'd0, 18'sd500, 18'sd500, 17'd0, 17'd100, 0, '0});
    dir.push_back('{ACT_MATCH, 6'd6, 18'sd500, 18'sd500, 17'd0, 17'd100, 0, '0});
    dir.push_back('{ACT_CLEAR, 6'd0, 18'sd0, 18'sd0, 17'd0, 17'd0, 1, '0});
    dir.push_back('{ACT_MATCH, 6'd0, 18'sd0, 18'sd0, 17'd160, 17'd160, 1, '0});
    foreach (dir[i])
      send_item(dir[i].act, dir[i].trk, dir[i].x, dir[i].y, dir[i].w, dir[i].h,
                dir[i].typed, dir[i].res);

    thr_plan = '{16'd0, 16'd65535, 16'd20000, 16'($urandom), 16'd45000};
    gap_plan = '{0, 10, 88, 0, 10};
    stall_plan = '{0, 10, 0, 88, 10};
    for (int p = 0; p < 5; p++) begin
      write_threshold(thr_plan[p]);
      gap_pct = gap_plan[p];
      stall_pct = stall_plan[p];
      while (items < 25 + (p + 1) * 170) run_frame();
    end
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (failures == 0 && pending.size() == 0) begin
      $display("iou_track_association regression: pass");
    end else begin
      $display("iou_track_association regression: fail");
    end
    $finish;
  end

endmodule
